// File: hdl/event_log_record_decoder_defines.svh
// Assertion macros for the event log record decoder RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef EVENT_LOG_RECORD_DECODER_DEFINES_SVH
`define EVENT_LOG_RECORD_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ERD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("erd assertion failed");

// Next-cycle implication, disabled during reset.
`define ERD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("erd assertion failed");

`endif

// File: hdl/erd_pkg.sv
// Types and constants for the event log record decoder.
// No dependencies; used by erd_decode and event_log_record_decoder.
`default_nettype none

package erd_pkg;

  localparam int unsigned TimeShift = 3;

  // lead byte types, bits 7:6
  localparam logic [1:0] LEAD_CMD     = 2'd0;
  localparam logic [1:0] LEAD_NOTIFY  = 2'd1;
  localparam logic [1:0] LEAD_RELTIME = 2'd2;
  localparam logic [1:0] LEAD_EMIT    = 2'd3;

  // command values, bits 5:0
  localparam logic [5:0] CMD_BEGIN    = 6'd1;
  localparam logic [5:0] CMD_END      = 6'd2;
  localparam logic [5:0] CMD_OVERFLOW = 6'd3;
  localparam logic [5:0] CMD_MARKTIME = 6'd4;

  // trailing-byte state
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_MARK = 2'd1;
  localparam logic [1:0] PEND_EMIT = 2'd2;

  localparam logic [2:0] MARK_BYTES = 3'd4;

  typedef enum logic [2:0] {
    KIND_BEGIN    = 3'd0,
    KIND_END      = 3'd1,
    KIND_OVERFLOW = 3'd2,
    KIND_MARKTIME = 3'd3,
    KIND_NOTIFY   = 3'd4,
    KIND_EMIT     = 3'd5,
    KIND_RELTIME  = 3'd6,
    KIND_UNKNOWN  = 3'd7
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [5:0]  obj_idx;
    logic [5:0]  sig_idx;
    logic [5:0]  command_value;
    logic [31:0] current_time;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/erd_decode.sv
// Record decode state and per-byte decode logic.
// Depends on erd_pkg and event_log_record_decoder_defines.svh.
`default_nettype none

`include "event_log_record_decoder_defines.svh"

module erd_decode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       log_byte_i,
  output erd_pkg::result_t      result_o
);

  logic [31:0] time_q,     time_d;
  logic [1:0]  pend_q,     pend_d;
  logic [2:0]  remain_q,   remain_d;
  logic [31:0] assembly_q, assembly_d;
  logic [5:0]  held_q,     held_d;
  logic        stopped_q,  stopped_d;

  erd_pkg::result_t res;
  logic [1:0]       lead_type;
  logic [5:0]       lead_val;
  logic [31:0]      mark_shift;

  assign lead_type  = log_byte_i[7:6];
  assign lead_val   = log_byte_i[5:0];
  assign mark_shift = {log_byte_i, assembly_q[31:8]};

  always_comb begin
    time_d     = time_q;
    pend_d     = pend_q;
    remain_d   = remain_q;
    assembly_d = assembly_q;
    held_d     = held_q;
    stopped_d  = stopped_q;

    res               = '0;
    res.kind          = erd_pkg::KIND_BEGIN;

    if (take_i && !stopped_q) begin
      case (pend_q)
        erd_pkg::PEND_MARK: begin
          assembly_d = mark_shift;
          if (remain_q <= 3'd1) begin
            remain_d  = 3'd0;
            pend_d    = erd_pkg::PEND_NONE;
            time_d    = mark_shift;
            res.valid = 1'b1;
            res.kind  = erd_pkg::KIND_MARKTIME;
          end else begin
            remain_d = remain_q - 3'd1;
          end
        end
        erd_pkg::PEND_EMIT: begin
          pend_d      = erd_pkg::PEND_NONE;
          remain_d    = 3'd0;
          res.valid   = 1'b1;
          res.kind    = erd_pkg::KIND_EMIT;
          res.obj_idx = held_q;
          res.sig_idx = lead_val;
        end
        default: begin
          // no trailing bytes due (unused code treated the same)
          pend_d = erd_pkg::PEND_NONE;
          case (lead_type)
            erd_pkg::LEAD_CMD: begin
              case (lead_val)
                erd_pkg::CMD_BEGIN: begin
                  res.valid = 1'b1;
                  res.kind  = erd_pkg::KIND_BEGIN;
                end
                erd_pkg::CMD_END: begin
                  stopped_d = 1'b1;
                  res.valid = 1'b1;
                  res.kind  = erd_pkg::KIND_END;
                end
                erd_pkg::CMD_OVERFLOW: begin
                  res.valid = 1'b1;
                  res.kind  = erd_pkg::KIND_OVERFLOW;
                end
                erd_pkg::CMD_MARKTIME: begin
                  pend_d     = erd_pkg::PEND_MARK;
                  remain_d   = erd_pkg::MARK_BYTES;
                  assembly_d = '0;
                end
                default: begin
                  stopped_d         = 1'b1;
                  res.valid         = 1'b1;
                  res.kind          = erd_pkg::KIND_UNKNOWN;
                  res.command_value = lead_val;
                end
              endcase
            end
            erd_pkg::LEAD_NOTIFY: begin
              res.valid   = 1'b1;
              res.kind    = erd_pkg::KIND_NOTIFY;
              res.obj_idx = lead_val;
            end
            erd_pkg::LEAD_RELTIME: begin
              time_d    = time_q + {23'd0, lead_val, 3'd0};
              res.valid = 1'b1;
              res.kind  = erd_pkg::KIND_RELTIME;
            end
            default: begin
              pend_d   = erd_pkg::PEND_EMIT;
              remain_d = 3'd1;
              held_d   = lead_val;
            end
          endcase
        end
      endcase
    end
    res.current_time = time_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q     <= '0;
      pend_q     <= erd_pkg::PEND_NONE;
      remain_q   <= '0;
      assembly_q <= '0;
      held_q     <= '0;
      stopped_q  <= 1'b0;
    end else begin
      time_q     <= time_d;
      pend_q     <= pend_d;
      remain_q   <= remain_d;
      assembly_q <= assembly_d;
      held_q     <= held_d;
      stopped_q  <= stopped_d;
    end
  end

  // once stopped, stays stopped and silent until reset
  `ERD_ASSERT_NEXT(a_stop_sticky, stopped_q, stopped_q)
  `ERD_ASSERT_NOW(a_stop_silent, stopped_q, !res.valid)
  // marktime countdown stays in range while pending
  `ERD_ASSERT_NOW(a_mark_count, pend_q == erd_pkg::PEND_MARK,
                  remain_q != 3'd0 && remain_q <= erd_pkg::MARK_BYTES)
  // time only moves on a reported marktime or reltime
  `ERD_ASSERT_NOW(a_time_move, time_d != time_q,
                  res.valid && (res.kind == erd_pkg::KIND_MARKTIME ||
                                res.kind == erd_pkg::KIND_RELTIME))

endmodule

`default_nettype wire

// File: hdl/event_log_record_decoder.sv
// Event log record decoder: one log byte in per transfer, one record out when complete.
// Path: input register, then decode, then result register.
// Throughput: one byte per cycle while the output is not stalled.
// Reset clears decode state, running time and both valid flags at once.
// Depends on erd_pkg and erd_decode.
`default_nettype none

module event_log_record_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  log_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       record_kind_o,
  output logic [5:0]       object_index_o,
  output logic [5:0]       signal_index_o,
  output logic [5:0]       command_value_o,
  output logic [31:0]      current_time_o
);

  logic             byte_valid_q;
  logic [7:0]       byte_q;
  logic             out_valid_q;
  erd_pkg::result_t out_q;
  erd_pkg::result_t res;
  logic             advance;

  // the staged byte moves on when the result register is free or draining
  assign advance    = byte_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = byte_valid_q && !advance;

  erd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (advance),
    .log_byte_i (byte_q),
    .result_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        byte_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= res.valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= log_byte_i;
    end
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign record_kind_o   = out_q.kind;
  assign object_index_o  = out_q.obj_idx;
  assign signal_index_o  = out_q.sig_idx;
  assign command_value_o = out_q.command_value;
  assign current_time_o  = out_q.current_time;

endmodule

`default_nettype wire
